### src/pnet_pkg.sv
// Shared types and constants for the packet noise EMA tracker.
// No dependencies; every other file but pnet_div imports this package.
`default_nettype none

package pnet_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int Q_W             = 32;
  localparam int PROD_W          = 48;   // 16-bit gain times 32-bit magnitude
  localparam int FRAC_SHIFT      = 8;
  localparam int MAX_SAMPLES_DEF = 1024;

  // Large-rise test: diff > ema*70/100 + ema  <=>  RISE_DEN*diff > RISE_NUM*ema
  localparam int RISE_NUM = 17;
  localparam int RISE_DEN = 10;
  localparam int CMP_W    = Q_W + 6;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_NUM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_NUM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIM  = 3'd5;

  localparam logic [SAMPLE_W-1:0] RST_FAST_NUM = 16'd1;
  localparam logic [SAMPLE_W-1:0] RST_FAST_DEN = 16'd8;
  localparam logic [SAMPLE_W-1:0] RST_SLOW_NUM = 16'd1;
  localparam logic [SAMPLE_W-1:0] RST_SLOW_DEN = 16'd64;
  localparam logic [SAMPLE_W-1:0] RST_LIMIT    = 16'hFFFF;

  // Divider operand select
  localparam logic DIV_MEAN = 1'b0;
  localparam logic DIV_GAIN = 1'b1;

  typedef struct packed {
    logic accum;       // add the accepted word to the packet sum
    logic clear_acc;   // clear sum and count
    logic div_start;
    logic div_sel;     // DIV_MEAN or DIV_GAIN
    logic latch_mean;
    logic latch_diff;  // register difference sign, magnitude and rise test
    logic load_first;  // seed the average
    logic reject;
    logic latch_prod;
    logic apply;       // add the gain step to the average
    logic load_out;
  } pnet_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mean_ok;     // mean within the active limit
    logic started;
    logic out_free;
  } pnet_sts_t;

endpackage

`default_nettype wire

### src/pnet_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module pnet_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!rem_sub[DVS_W]) begin
        rem_nxt = rem_sub[DVS_W-1:0];
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
      end
      quo_nxt  = {quo_r[DVD_W-2:0], ~rem_sub[DVS_W]};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### src/pnet_dp.sv
// Datapath: config registers, packet accumulator, EMA state, output register.
// Uses pnet_pkg and instantiates the shared divider pnet_div.
`default_nettype none

module pnet_dp
  import pnet_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pnet_cmd_t            cmd,
  output pnet_sts_t                 sts,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic      [SAMPLE_W-1:0]  out_packet_mean,
  output logic                      out_accepted,
  output logic      [Q_W-1:0]       out_smoothed_q,
  output logic      [Q_W-1:0]       out_packets_counted
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int DVS_W = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

  // config
  logic [SAMPLE_W-1:0] fast_num_r, fast_den_r, slow_num_r, slow_den_r;
  logic [SAMPLE_W-1:0] init_lim_r, run_lim_r;

  // packet accumulator
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // tracker state
  logic [Q_W-1:0] ema_r, ema_nxt;
  logic [Q_W-1:0] acc_cnt_r, acc_cnt_nxt;
  logic           started_r, started_nxt;
  logic           acc_flag_r, acc_flag_nxt;

  // per-packet working registers
  logic [SAMPLE_W-1:0] mean_r;
  logic [Q_W-1:0]      mag_r;
  logic                neg_r;
  logic                slow_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0] den_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_mean_r;
  logic                out_acc_r;
  logic [Q_W-1:0]      out_smooth_r;
  logic [Q_W-1:0]      out_cnt_r;

  logic [SAMPLE_W-1:0] limit;
  logic [Q_W-1:0]      x_q;
  logic [Q_W-1:0]      diff;
  logic [Q_W-1:0]      diff_mag;
  logic [CMP_W-1:0]    diff_scaled;
  logic [CMP_W-1:0]    ema_scaled;
  logic                big_rise;
  logic [SAMPLE_W-1:0] num_sel;
  logic [SAMPLE_W-1:0] den_sel;
  logic [PROD_W-1:0]   prod;
  logic [Q_W-1:0]      step_mag;
  logic [Q_W-1:0]      step;

  logic [PROD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_done;
  logic [PROD_W-1:0]   div_quo;

  // ---- config writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_num_r <= RST_FAST_NUM;
      fast_den_r <= RST_FAST_DEN;
      slow_num_r <= RST_SLOW_NUM;
      slow_den_r <= RST_SLOW_DEN;
      init_lim_r <= RST_LIMIT;
      run_lim_r  <= RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST_NUM: fast_num_r <= cfg_data;
        REG_FAST_DEN: fast_den_r <= cfg_data;
        REG_SLOW_NUM: slow_num_r <= cfg_data;
        REG_SLOW_DEN: slow_den_r <= cfg_data;
        REG_INIT_LIM: init_lim_r <= cfg_data;
        REG_RUN_LIM:  run_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- accumulator: words past MAX_SAMPLES are dropped ----
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.clear_acc) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.accum && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
      sum_nxt = sum_r + SUM_W'(in_sample);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // ---- decision and rise test ----
  assign limit    = started_r ? run_lim_r : init_lim_r;
  assign x_q      = Q_W'(mean_r) << FRAC_SHIFT;
  assign diff     = x_q - ema_r;
  assign diff_mag = diff[Q_W-1] ? (~diff + 1'b1) : diff;

  assign diff_scaled = CMP_W'(diff) * CMP_W'(RISE_DEN);
  assign ema_scaled  = CMP_W'(ema_r) * CMP_W'(RISE_NUM);
  assign big_rise    = !diff[Q_W-1] && (diff_scaled > ema_scaled);

  assign num_sel = slow_r ? slow_num_r : fast_num_r;
  assign den_sel = slow_r ? slow_den_r : fast_den_r;
  assign prod    = {{(PROD_W-SAMPLE_W){1'b0}}, num_sel} * {{(PROD_W-Q_W){1'b0}}, mag_r};

  // quotient truncates toward zero; low 32 bits of the signed step
  assign step_mag = div_quo[Q_W-1:0];
  assign step     = neg_r ? (~step_mag + 1'b1) : step_mag;

  always_comb begin
    ema_nxt      = ema_r;
    acc_cnt_nxt  = acc_cnt_r;
    started_nxt  = started_r;
    acc_flag_nxt = acc_flag_r;
    if (cmd.reject) begin
      acc_flag_nxt = 1'b0;
    end else if (cmd.load_first) begin
      ema_nxt      = x_q;
      started_nxt  = 1'b1;
      acc_cnt_nxt  = acc_cnt_r + 1'b1;
      acc_flag_nxt = 1'b1;
    end else if (cmd.apply) begin
      ema_nxt      = ema_r + step;
      acc_cnt_nxt  = acc_cnt_r + 1'b1;
      acc_flag_nxt = 1'b1;
    end
  end

  // ---- shared divider ----
  assign div_dvd = (cmd.div_sel == DIV_GAIN) ? prod_r
                                             : {{(PROD_W-SUM_W){1'b0}}, sum_r};
  assign div_dvs = (cmd.div_sel == DIV_GAIN) ? DVS_W'(den_r) : DVS_W'(cnt_r);

  pnet_div #(
    .DVD_W (PROD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ema_r       <= '0;
      acc_cnt_r   <= '0;
      started_r   <= 1'b0;
      acc_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ema_r       <= ema_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      started_r   <= started_nxt;
      acc_flag_r  <= acc_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.latch_mean) begin
      mean_r <= div_quo[SAMPLE_W-1:0];
    end
    if (cmd.latch_diff) begin
      mag_r  <= diff_mag;
      neg_r  <= diff[Q_W-1];
      slow_r <= big_rise;
    end
    if (cmd.latch_prod) begin
      prod_r <= prod;
      den_r  <= (den_sel == '0) ? SAMPLE_W'(1) : den_sel;
    end
    if (cmd.load_out) begin
      out_mean_r   <= mean_r;
      out_acc_r    <= acc_flag_r;
      out_smooth_r <= ema_r;
      out_cnt_r    <= acc_cnt_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.mean_ok  = (mean_r <= limit);
  assign sts.started  = started_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_packet_mean     = out_mean_r;
  assign out_accepted        = out_acc_r;
  assign out_smoothed_q      = out_smooth_r;
  assign out_packets_counted = out_cnt_r;

endmodule

`default_nettype wire

### src/pnet_ctrl.sv
// Controller FSM: sequences collect, mean divide, limit check, multiply and gain divide (update only), output.
// Uses pnet_pkg command and status types.
`default_nettype none

module pnet_ctrl
  import pnet_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_stall,
  input  wire pnet_sts_t sts,
  output pnet_cmd_t      cmd
);

  localparam logic [2:0] S_COLLECT    = 3'd0;
  localparam logic [2:0] S_MEAN_START = 3'd1;
  localparam logic [2:0] S_MEAN_WAIT  = 3'd2;
  localparam logic [2:0] S_DECIDE     = 3'd3;
  localparam logic [2:0] S_MUL        = 3'd4;
  localparam logic [2:0] S_GAIN_START = 3'd5;
  localparam logic [2:0] S_GAIN_WAIT  = 3'd6;
  localparam logic [2:0] S_OUT        = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_COLLECT: begin
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (in_last) begin
            state_nxt = S_MEAN_START;
          end
        end
      end
      S_MEAN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        cmd.clear_acc = 1'b1;
        state_nxt     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (sts.div_done) begin
          cmd.latch_mean = 1'b1;
          state_nxt      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.latch_diff = 1'b1;
        priority if (!sts.mean_ok) begin
          cmd.reject = 1'b1;
          state_nxt  = S_OUT;
        end else if (!sts.started) begin
          cmd.load_first = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.latch_prod = 1'b1;
        state_nxt      = S_GAIN_START;
      end
      S_GAIN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GAIN;
        state_nxt     = S_GAIN_WAIT;
      end
      S_GAIN_WAIT: begin
        cmd.div_sel = DIV_GAIN;
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_COLLECT;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_COLLECT);

endmodule

`default_nettype wire

### src/packet_noise_ema_tracker_top.sv
// A packet is taken one word per cycle while collecting; the result word follows
//   the last word after two 48-step divisions when it updates the average and
//   after one when the packet is rejected or seeds the average.
// Input stalls from each last word until the result word is loaded, longer while
//   an earlier result word is still held.
// Reset: synchronous active-low rst_n clears packet, average, count, output valid.
`default_nettype none

module packet_noise_ema_tracker_top
  import pnet_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF  // words summed per packet, rest dropped
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // sample words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 in_last,
  // one result word per packet
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [SAMPLE_W-1:0]  out_packet_mean,
  output logic                      out_accepted,
  output logic      [Q_W-1:0]       out_smoothed_q,
  output logic      [Q_W-1:0]       out_packets_counted,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data
);

  pnet_cmd_t cmd;
  pnet_sts_t sts;

  // Registers are always writable; software writes only while the block is idle.
  assign cfg_ready = 1'b1;

  // Controller: one word per cycle while collecting, then walks the packet through mean
  // divide, limit check, multiply and gain divide (update only) and output load.
  pnet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: accumulator, shared divider, EMA state and the output register,
  // which lets a finished result wait while the next packet is collected.
  pnet_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_sample           (in_sample),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_packet_mean     (out_packet_mean),
    .out_accepted        (out_accepted),
    .out_smoothed_q      (out_smoothed_q),
    .out_packets_counted (out_packets_counted)
  );

endmodule

`default_nettype wire

### src/pnet_checker.sv
// Port-level checker for the packet noise EMA tracker, bound to the top level.
// Uses pnet_pkg widths.
`default_nettype none

module pnet_checker
  import pnet_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 in_last,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [SAMPLE_W-1:0]  out_packet_mean,
  input wire logic                 out_accepted,
  input wire logic [Q_W-1:0]       out_smoothed_q,
  input wire logic [Q_W-1:0]       out_packets_counted
);

  logic           out_take;
  logic           seen_r, seen_nxt;
  logic [Q_W-1:0] prev_cnt_r, prev_cnt_nxt;
  logic [Q_W-1:0] prev_q_r, prev_q_nxt;
  logic [Q_W-1:0] base_cnt, base_q;

  assign out_take = out_valid && !out_stall;
  assign base_cnt = seen_r ? prev_cnt_r : '0;
  assign base_q   = seen_r ? prev_q_r : '0;

  always_comb begin
    seen_nxt     = seen_r;
    prev_cnt_nxt = prev_cnt_r;
    prev_q_nxt   = prev_q_r;
    if (out_take) begin
      seen_nxt     = 1'b1;
      prev_cnt_nxt = out_packets_counted;
      prev_q_nxt   = out_smoothed_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      prev_cnt_r <= '0;
      prev_q_r   <= '0;
    end else begin
      seen_r     <= seen_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      prev_q_r   <= prev_q_nxt;
    end
  end

  // input stalls only after taking the word that closes a packet
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && in_last))
    else $error("input stall without a closing word");

  // a new result appears only while packet work holds the input
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while collecting");

  // count advances by one per accepted packet, holds otherwise
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |-> (out_packets_counted == base_cnt + Q_W'(out_accepted)))
    else $error("packet count out of step");

  // rejected packet leaves the average unchanged
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_accepted) |-> (out_smoothed_q == base_q))
    else $error("average moved on a rejected packet");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_packet_mean)
      && $stable(out_smoothed_q) && $stable(out_packets_counted)))
    else $error("stalled result changed");

endmodule

bind packet_noise_ema_tracker_top pnet_checker u_pnet_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_noise_ema_tracker_top: per-packet mean, outlier gate
// and EMA update predicted in-bench and compared field by field. Depends on pnet_pkg and the DUT.

module testbench;
  import pnet_pkg::*;

  localparam int SETTLE_CYCLES = 160;   // longer than the worst per-packet latency
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 50;
  localparam int LONG_WORDS    = 1030;  // past MAX_SAMPLES, so the tail, last word included, is left out of the sum

  // One result word as the block reports it
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                accepted;
    logic [Q_W-1:0]      smoothed_q;
    logic [Q_W-1:0]      count;
  } noise_report_t;

  // Directed row: typed = 1 means the expectation is taken from the row, not the predictor
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                typed;
    noise_report_t       want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  out_packet_mean;
  logic                 out_accepted;
  logic [Q_W-1:0]       out_smoothed_q;
  logic [Q_W-1:0]       out_packets_counted;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;

  packet_noise_ema_tracker_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_packet_mean     (out_packet_mean),
    .out_accepted        (out_accepted),
    .out_smoothed_q      (out_smoothed_q),
    .out_packets_counted (out_packets_counted),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tracker mirror: register shadow plus packet / average state
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] reg_shadow [0:5];
  logic [25:0]         pkt_sum = '0;
  logic [10:0]         pkt_words = '0;
  logic [Q_W-1:0]      ema_q = '0;
  logic                ema_seeded = 1'b0;
  logic [Q_W-1:0]      accept_total = '0;

  noise_report_t expected_reports [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  initial begin
    reg_shadow[REG_FAST_NUM] = RST_FAST_NUM;
    reg_shadow[REG_FAST_DEN] = RST_FAST_DEN;
    reg_shadow[REG_SLOW_NUM] = RST_SLOW_NUM;
    reg_shadow[REG_SLOW_DEN] = RST_SLOW_DEN;
    reg_shadow[REG_INIT_LIM] = RST_LIMIT;
    reg_shadow[REG_RUN_LIM]  = RST_LIMIT;
  end

  // gain * diff, truncated toward zero; a zero denominator counts as one
  function automatic logic [Q_W-1:0] scaled_step(longint diff, logic [15:0] num,
                                                 logic [15:0] den);
    longint d;
    longint q;
    d = (den == 16'd0) ? 64'sd1 : longint'(den);
    q = (longint'(num) * diff) / d;
    return q[31:0];
  endfunction

  // Fold one accepted word into the mirror; a last word closes the packet
  task automatic predict_word(input logic [SAMPLE_W-1:0] s, input logic l,
                              output logic produced, output noise_report_t r);
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] limit;
    logic [Q_W-1:0]      xq;
    logic signed [31:0]  d32;
    longint              diff;
    logic [63:0]         bound;
    logic                big_rise;
    produced = 1'b0;
    r = '0;
    if (pkt_words < MAX_SAMPLES_DEF) begin
      pkt_sum   = pkt_sum + 26'(s);
      pkt_words = pkt_words + 1'b1;
    end
    if (!l) return;
    mean = 16'(pkt_sum / pkt_words);
    pkt_sum = '0;
    pkt_words = '0;
    limit = ema_seeded ? reg_shadow[REG_RUN_LIM] : reg_shadow[REG_INIT_LIM];
    r.mean = mean;
    r.accepted = 1'b0;
    if (mean <= limit) begin
      xq = {16'd0, mean} << FRAC_SHIFT;
      if (!ema_seeded) begin
        ema_q = xq;
        ema_seeded = 1'b1;
      end else begin
        d32 = xq - ema_q;
        diff = longint'(d32);
        bound = ({32'd0, ema_q} * 64'd70) / 64'd100 + {32'd0, ema_q};
        big_rise = (diff > 0) && (64'(diff) > bound);
        if (big_rise)
          ema_q = ema_q + scaled_step(diff, reg_shadow[REG_SLOW_NUM], reg_shadow[REG_SLOW_DEN]);
        else
          ema_q = ema_q + scaled_step(diff, reg_shadow[REG_FAST_NUM], reg_shadow[REG_FAST_DEN]);
      end
      accept_total = accept_total + 1'b1;
      r.accepted = 1'b1;
    end
    r.smoothed_q = ema_q;
    r.count = accept_total;
    produced = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 100)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Result monitor: sampled at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    noise_report_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result word with nothing pending, mean", 32'(out_packet_mean),
                        32'd0);
      end else begin
        want = expected_reports.pop_front();
        check_field("packet_mean", 32'(out_packet_mean), 32'(want.mean));
        check_field("accepted", 32'(out_accepted), 32'(want.accepted));
        check_field("smoothed_q", out_smoothed_q, want.smoothed_q);
        check_field("packets_counted", out_packets_counted, want.count);
      end
    end
  end

  // Receiver: random stall per cycle, or a long hold-off when one is requested.
  // During the hold the sender keeps offering words, so the block backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Offer one sample word, hold it until taken, then fold it into the mirror.
  // valid stays high into the next word when the sender does not idle.
  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic l,
                           input logic typed, input noise_report_t want);
    logic          produced;
    noise_report_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(s, l, produced, predicted);
    if (produced) expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // All results in, then let the back stage settle before touching registers
  task automatic wait_idle();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_shadow[idx] = val;
  endtask

  task automatic set_registers(input logic [15:0] fnum, input logic [15:0] fden,
                               input logic [15:0] snum, input logic [15:0] sden,
                               input logic [15:0] ilim, input logic [15:0] rlim);
    wait_idle();
    write_reg(REG_FAST_NUM, fnum);
    write_reg(REG_FAST_DEN, fden);
    write_reg(REG_SLOW_NUM, snum);
    write_reg(REG_SLOW_DEN, sden);
    write_reg(REG_INIT_LIM, ilim);
    write_reg(REG_RUN_LIM,  rlim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Packet content styles: full random, close to the current average (fast path,
  // small diffs), all zero (mean 0, passes even a zero limit), all ones, small noise.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int style);
    if (style < 30) return 16'($urandom);
    if (style < 65) return ema_q[23:8] + 16'($urandom_range(0, 63)) - 16'd32;
    if (style < 75) return 16'h0000;
    if (style < 80) return 16'hFFFF;
    return 16'($urandom_range(0, 255));
  endfunction

  // Mostly short packets, now and then a longer one; optional overlong packet first
  task automatic random_phase(input int n_words, input logic with_long);
    int            sent;
    int            len;
    int            style;
    noise_report_t none;
    none = '0;
    sent = 0;
    if (with_long) begin
      for (int i = 0; i < LONG_WORDS; i++)
        send_word(16'($urandom), i == LONG_WORDS - 1, 1'b0, none);
    end
    while (sent < n_words) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      style = $urandom_range(0, 99);
      for (int k = 0; k < len; k++)
        send_word(pick_sample(style), k == len - 1, 1'b0, none);
      sent += len;
    end
    end_burst();
  endtask

  task automatic random_registers();
    set_registers(16'($urandom), 16'($urandom_range(0, 65535)), 16'($urandom),
                  16'($urandom_range(0, 300)), 16'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Run with initial_limit = 100: the first two packets bounce off
  // it, the third lands exactly on it and seeds the average. Then a large rise
  // (slow gain), a drop to zero (fast gain, negative step), alternating bit
  // patterns, a floor-rounded mean and a mean of all-ones/zero.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [0:14] = '{
    '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b0, 32'd0,     32'd0}},
    '{16'd101,  1'b1, 1'b1, '{16'd101,  1'b0, 32'd0,     32'd0}},
    '{16'd100,  1'b1, 1'b1, '{16'd100,  1'b1, 32'd25600, 32'd1}},
    '{16'hFFFF, 1'b1, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b0, '0},
    '{16'hAAAA, 1'b0, 1'b0, '0},
    '{16'h5555, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0},
    '{16'h7FFF, 1'b1, 1'b0, '0},
    '{16'd3,    1'b0, 1'b0, '0},
    '{16'd4,    1'b1, 1'b0, '0},
    '{16'd120,  1'b1, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain;
    noise_report_t left;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender sparse gaps, receiver stalls most cycles
    send_idle_pct = 12;
    recv_idle_pct = 81;
    set_registers(RST_FAST_NUM, RST_FAST_DEN, RST_SLOW_NUM, RST_SLOW_DEN, 16'd100, RST_LIMIT);
    foreach (directed_rows[i])
      send_word(directed_rows[i].sample, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    end_burst();

    // Defaults
    set_registers(RST_FAST_NUM, RST_FAST_DEN, RST_SLOW_NUM, RST_SLOW_DEN, RST_LIMIT, RST_LIMIT);
    random_phase(PHASE_WORDS, 1'b0);
    // Zero limit: only packets with mean zero get in; max fast gain with zero denominator
    set_registers(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    random_phase(PHASE_WORDS, 1'b0);

    // Now the sender idles heavily, the receiver rarely
    send_idle_pct = 81;
    recv_idle_pct = 12;
    // Huge gains, average wraps 32 bits; slow denominator zero
    set_registers(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, RST_LIMIT, RST_LIMIT);
    random_phase(PHASE_WORDS, 1'b0);
    // Frozen fast path, half-step slow path, mid running limit; long receiver hold
    set_registers(16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd12345, 16'd30000);
    hold_cycles = HOLD_CYCLES;
    random_phase(PHASE_WORDS, 1'b0);

    // Back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_registers();
    random_phase(PHASE_WORDS, 1'b0);
    random_registers();
    random_phase(PHASE_WORDS, 1'b0);
    // Defaults again, with one overlong packet up front
    set_registers(RST_FAST_NUM, RST_FAST_DEN, RST_SLOW_NUM, RST_SLOW_DEN, RST_LIMIT, RST_LIMIT);
    random_phase(PHASE_WORDS, 1'b1);

    // Drain, bounded; whatever is still pending never came out
    drain = 0;
    while (expected_reports.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_reports.size() != 0) begin
      left = expected_reports.pop_front();
      report_mismatch("result never arrived, mean", 32'd0, 32'(left.mean));
    end

    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
